// File: rtl/t2u8_pkg.sv
// shared types, constants and byte encoding function for the utf-8 transcoder
package t2u8_pkg;

  localparam logic [15:0] SUR_HIGH_MIN = 16'hD800;
  localparam logic [15:0] SUR_HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] SUR_LOW_MIN  = 16'hDC00;
  localparam logic [15:0] SUR_LOW_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;
  localparam logic [5:0]  SUR_HIGH_TAG = 6'b110110;

  // configuration register indexes
  localparam logic CFG_SOURCE_FORMAT   = 1'b0;
  localparam logic CFG_SKIP_FIRST_UNIT = 1'b1;

  // source format codes
  localparam logic FMT_LATIN1 = 1'b0;
  localparam logic FMT_UTF16  = 1'b1;

  localparam int MAX_BYTES = 6;

  // up to four bytes of one code point
  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      len;
  } cp_bytes_t;

  // all bytes caused by one transaction
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      str_end;
    logic                      err;
  } result_t;

  // transcoder state
  typedef struct packed {
    logic       pending;
    logic [9:0] held;
    logic       at_start;
  } state_t;

  function automatic cp_bytes_t encode_cp(input logic [20:0] cp);
    cp_bytes_t r;
    r = '0;
    if (cp < 21'h80) begin
      r.len  = 3'd1;
      r.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      r.len  = 3'd2;
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
    end else if (cp < SUPP_BASE) begin
      r.len  = 3'd3;
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
    end else begin
      r.len  = 3'd4;
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
    end
    return r;
  endfunction

endpackage

// File: rtl/text_to_utf8_transcoder_top.sv
// top level of the utf-16 / latin-1 to utf-8 transcoder
// path: an accepted unit waits in the input register, then its bytes load the result register
// throughput: one input transaction per cycle when it yields no byte, or one byte the receiver
//   does not stall; more bytes (up to six) hold the input until the byte-wide port drains them
// reset: synchronous active-low rst_n clears all control state, source_format
//   returns to utf-16, skip_first_unit to 0, and the next unit starts a string
module text_to_utf8_transcoder_top (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_code_unit,
  input  logic        in_last_unit,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_run_last,
  output logic        out_string_end,
  output logic        out_error_flag,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic        cfg_data
);

  // configuration registers
  logic source_format_r;
  logic skip_first_r;

  // input register stage
  logic        in_v_r, in_v_nxt;
  logic [15:0] unit_r;
  logic        last_r;
  logic        in_take;
  logic        move;

  // transcoder state, updated when a transaction leaves the input register
  t2u8_pkg::state_t  state_r;
  t2u8_pkg::state_t  state_nxt;
  t2u8_pkg::result_t result;
  logic              can_load;
  logic              load;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      source_format_r <= t2u8_pkg::FMT_UTF16;
      skip_first_r    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        t2u8_pkg::CFG_SOURCE_FORMAT:   source_format_r <= cfg_data;
        t2u8_pkg::CFG_SKIP_FIRST_UNIT: skip_first_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // a held transaction leaves when the serializer frees up, or at once if it
  // makes no bytes (dropped bom or held high surrogate)
  assign move     = in_v_r && (can_load || result.count == 3'd0);
  assign load     = move && result.count != 3'd0;
  assign in_stall = in_v_r && !move;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_take) begin
      in_v_nxt = 1'b1;
    end else if (move) begin
      in_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      unit_r <= in_code_unit;
      last_r <= in_last_unit;
    end
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      state_r <= '{pending: 1'b0, held: 10'd0, at_start: 1'b1};
    end else begin
      in_v_r <= in_v_nxt;
      if (move) begin
        state_r <= state_nxt;
      end
    end
  end

  t2u8_encode u_encode (
    .source_format   (source_format_r),
    .skip_first_unit (skip_first_r),
    .code_unit       (unit_r),
    .last_unit       (last_r),
    .state           (state_r),
    .result          (result),
    .state_nxt       (state_nxt)
  );

  t2u8_serializer u_serializer (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (load),
    .result         (result),
    .can_load       (can_load),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end),
    .out_error_flag (out_error_flag)
  );

endmodule

// File: rtl/t2u8_encode.sv
// combinational encoder: one code unit plus state into up to six utf-8 bytes
module t2u8_encode (
  input  logic                 source_format,
  input  logic                 skip_first_unit,
  input  logic [15:0]          code_unit,
  input  logic                 last_unit,
  input  t2u8_pkg::state_t     state,
  output t2u8_pkg::result_t    result,
  output t2u8_pkg::state_t     state_nxt
);

  t2u8_pkg::cp_bytes_t a;
  t2u8_pkg::cp_bytes_t b;
  logic                is_high;
  logic                is_low;
  logic                done;
  logic                err;
  logic [2:0]          pos;
  logic [2:0]          j;

  always_comb begin
    a         = '0;
    b         = '0;
    done      = 1'b0;
    err       = 1'b0;
    is_high   = code_unit inside {[t2u8_pkg::SUR_HIGH_MIN:t2u8_pkg::SUR_HIGH_MAX]};
    is_low    = code_unit inside {[t2u8_pkg::SUR_LOW_MIN:t2u8_pkg::SUR_LOW_MAX]};
    state_nxt = state;
    state_nxt.at_start = last_unit;

    if (source_format == t2u8_pkg::FMT_LATIN1) begin
      state_nxt.pending = 1'b0;
      b = t2u8_pkg::encode_cp({13'd0, code_unit[7:0]});
    end else if (state.at_start && skip_first_unit) begin
      // first unit of the string dropped as a byte order mark
      state_nxt.pending = 1'b0;
    end else begin
      if (state.pending) begin
        state_nxt.pending = 1'b0;
        if (is_low) begin
          a = t2u8_pkg::encode_cp(t2u8_pkg::SUPP_BASE +
                                  {1'b0, state.held, code_unit[9:0]});
          done = 1'b1;
        end else begin
          a = t2u8_pkg::encode_cp({5'd0, t2u8_pkg::SUR_HIGH_TAG, state.held});
        end
      end
      if (!done) begin
        if (is_high) begin
          if (last_unit) begin
            b.len = 3'd1;
            err   = 1'b1;
          end else begin
            state_nxt.pending = 1'b1;
            state_nxt.held    = code_unit[9:0];
          end
        end else begin
          b = t2u8_pkg::encode_cp({5'd0, code_unit});
        end
      end
    end

    // released surrogate bytes first, then this unit's bytes
    for (int i = 0; i < t2u8_pkg::MAX_BYTES; i++) begin
      pos = 3'(i);
      j   = pos - a.len;
      if (pos < a.len) begin
        result.bytes[i] = a.b[pos[1:0]];
      end else begin
        result.bytes[i] = b.b[j[1:0]];
      end
    end
    result.count   = a.len + b.len;
    result.str_end = last_unit;
    result.err     = err;
  end

endmodule

// File: rtl/t2u8_serializer.sv
// result register that shifts out one byte per transaction
module t2u8_serializer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  t2u8_pkg::result_t  result,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_byte,
  output logic               out_run_last,
  output logic               out_string_end,
  output logic               out_error_flag
);

  logic [t2u8_pkg::MAX_BYTES-1:0][7:0] bytes_r, bytes_nxt;
  logic [2:0]                          rem_r, rem_nxt;
  logic                                end_r, end_nxt;
  logic                                err_r, err_nxt;
  logic                                take;

  assign take      = out_valid && !out_stall;
  assign can_load  = (rem_r == 3'd0) || (rem_r == 3'd1 && take);
  assign out_valid = rem_r != 3'd0;
  assign out_byte  = bytes_r[0];
  assign out_run_last   = rem_r == 3'd1;
  assign out_string_end = end_r && rem_r == 3'd1;
  assign out_error_flag = err_r && rem_r == 3'd1;

  always_comb begin
    bytes_nxt = bytes_r;
    rem_nxt   = rem_r;
    end_nxt   = end_r;
    err_nxt   = err_r;
    if (load) begin
      bytes_nxt = result.bytes;
      rem_nxt   = result.count;
      end_nxt   = result.str_end;
      err_nxt   = result.err;
    end else if (take) begin
      bytes_nxt = {8'd0, bytes_r[t2u8_pkg::MAX_BYTES-1:1]};
      rem_nxt   = rem_r - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r <= bytes_nxt;
    end_r   <= end_nxt;
    err_r   <= err_nxt;
    if (!rst_n) begin
      rem_r <= 3'd0;
    end else begin
      rem_r <= rem_nxt;
    end
  end

endmodule

// File: rtl/t2u8_checker.sv
// port-level checker for the transcoder and its bind
module t2u8_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic        out_run_last,
  input logic        out_string_end,
  input logic        out_error_flag
);

  // a stalled result byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte) &&
                               $stable(out_run_last) && $stable(out_string_end))
    else $error("stalled result changed");

  // an error result ends in a zero byte that ends the string
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error_flag |-> out_byte == 8'd0 && out_run_last && out_string_end)
    else $error("malformed error result");

  // string end only on the last byte of a transaction
  a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_string_end |-> out_run_last)
    else $error("string end before run end");

  // reset empties both stages
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("not empty after reset");

endmodule

bind text_to_utf8_transcoder_top t2u8_checker u_t2u8_checker (.*);

// File: bench/tb_text_to_utf8_transcoder_top.sv
// self-checking testbench for the utf-16 / latin-1 to utf-8 transcoder
`timescale 1ns / 1ps

module tb_text_to_utf8_transcoder_top;

  // cycles with no transaction at all before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  // extra cycles after the last expected byte, covers units that yield nothing
  localparam int DRAIN_CYCLES = 8;
  // length of the long receiver hold-off
  localparam int HOLD_OFF_CYCLES = 300;
  // input units sent per random block
  localparam int BLOCK_UNITS = 35;

  // predicts the utf-8 byte stream and checks the block's bytes against it
  class utf8_scoreboard;
    typedef struct packed {
      logic [7:0] data;
      logic       run_last;
      logic       string_end;
      logic       error_flag;
    } utf8_byte_t;

    logic       source_format;
    logic       skip_first;
    logic       sur_pending;
    logic [9:0] held_bits;
    logic       at_start;
    logic [8:0] run_bytes[$];
    utf8_byte_t expected_bytes[$];
    int         fail_count;

    function new();
      source_format = t2u8_pkg::FMT_UTF16;
      skip_first    = 1'b0;
      sur_pending   = 1'b0;
      held_bits     = '0;
      at_start      = 1'b1;
      fail_count    = 0;
    endfunction

    function void write_reg(input logic idx, input logic val);
      if (idx == t2u8_pkg::CFG_SOURCE_FORMAT) source_format = val;
      else if (idx == t2u8_pkg::CFG_SKIP_FIRST_UNIT) skip_first = val;
    endfunction

    function void push_byte(input logic [7:0] b, input logic err);
      run_bytes.push_back({err, b});
    endfunction

    function void push_code_point(input logic [20:0] cp);
      if (cp < 21'h80) begin
        push_byte(cp[7:0], 1'b0);
      end else if (cp < 21'h800) begin
        push_byte(8'hC0 | cp[10:6], 1'b0);
        push_byte(8'h80 | cp[5:0], 1'b0);
      end else if (cp < 21'h10000) begin
        push_byte(8'hE0 | cp[15:12], 1'b0);
        push_byte(8'h80 | cp[11:6], 1'b0);
        push_byte(8'h80 | cp[5:0], 1'b0);
      end else begin
        push_byte(8'hF0 | cp[20:18], 1'b0);
        push_byte(8'h80 | cp[17:12], 1'b0);
        push_byte(8'h80 | cp[11:6], 1'b0);
        push_byte(8'h80 | cp[5:0], 1'b0);
      end
    endfunction

    // one accepted input transaction
    function void note_unit(input logic [15:0] unit, input logic last);
      logic       first;
      logic       is_high;
      logic       is_low;
      logic       paired;
      logic [7:0] lo;
      utf8_byte_t e;
      first    = at_start;
      at_start = last;
      is_high  = (unit >= 16'hD800) && (unit <= 16'hDBFF);
      is_low   = (unit >= 16'hDC00) && (unit <= 16'hDFFF);
      paired   = 1'b0;
      lo       = unit[7:0];
      if (source_format == t2u8_pkg::FMT_LATIN1) begin
        sur_pending = 1'b0;
        if (lo < 8'h80) begin
          push_byte(lo, 1'b0);
        end else begin
          push_byte((lo > 8'hBF) ? 8'hC3 : 8'hC2, 1'b0);
          push_byte({2'b10, lo[5:0]}, 1'b0);
        end
      end else if (first && skip_first) begin
        sur_pending = 1'b0;
      end else begin
        if (sur_pending) begin
          sur_pending = 1'b0;
          if (is_low) begin
            push_code_point({1'b0, held_bits, unit[9:0]} + 21'h10000);
            paired = 1'b1;
          end else begin
            push_code_point(21'hD800 | held_bits);
          end
        end
        if (!paired) begin
          if (is_high) begin
            if (last) begin
              push_byte(8'h00, 1'b1);
            end else begin
              sur_pending = 1'b1;
              held_bits   = unit[9:0];
            end
          end else begin
            push_code_point({5'd0, unit});
          end
        end
      end
      foreach (run_bytes[i]) begin
        e.data       = run_bytes[i][7:0];
        e.error_flag = run_bytes[i][8];
        e.run_last   = (i == run_bytes.size() - 1);
        e.string_end = e.run_last && last;
        expected_bytes.push_back(e);
      end
      run_bytes.delete();
    endfunction

    // one accepted result transaction
    function void check_byte(input logic [7:0] b, input logic rl, input logic se,
                             input logic ef);
      utf8_byte_t e;
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte %02h with nothing outstanding", b);
        fail_count++;
      end else begin
        e = expected_bytes.pop_front();
        if (b !== e.data) begin
          $error("out_byte: expected %02h, got %02h", e.data, b);
          fail_count++;
        end
        if (rl !== e.run_last) begin
          $error("out_run_last: expected %0b, got %0b", e.run_last, rl);
          fail_count++;
        end
        if (se !== e.string_end) begin
          $error("out_string_end: expected %0b, got %0b", e.string_end, se);
          fail_count++;
        end
        if (ef !== e.error_flag) begin
          $error("out_error_flag: expected %0b, got %0b", e.error_flag, ef);
          fail_count++;
        end
      end
    endfunction

    function int outstanding();
      return expected_bytes.size();
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [15:0] in_code_unit;
  logic        in_last_unit;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_run_last;
  logic        out_string_end;
  logic        out_error_flag;
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_index;
  logic        cfg_data;

  utf8_scoreboard sb;

  // idle percentages of sender and receiver, changed per phase
  int in_idle_pct;
  int out_idle_pct;
  // remaining cycles of a forced receiver hold-off
  int hold_cycles;
  int sent_units;
  int quiet_cycles;

  text_to_utf8_transcoder_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_code_unit   (in_code_unit),
    .in_last_unit   (in_last_unit),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_string_end (out_string_end),
    .out_error_flag (out_error_flag),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver: random stall, or a long counted hold-off when one is requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall   = 1'b1;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_stall = ($urandom_range(0, 99) < out_idle_pct);
      end
    end
  end

  // monitor: every transaction on the three channels, plus the hang watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_unit(in_code_unit, in_last_unit);
      if (out_valid && !out_stall)
        sb.check_byte(out_byte, out_run_last, out_string_end, out_error_flag);
      if (cfg_valid && cfg_ready)
        sb.write_reg(cfg_index, cfg_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("text_to_utf8_transcoder_top regression: fail");
        $finish;
      end
    end
  end

  // one input transaction; called at a falling edge, returns at a falling edge
  task automatic send_unit(input logic [15:0] unit, input logic last);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_code_unit = unit;
    in_last_unit = last;
    do @(posedge clk); while (in_stall);
    sent_units = sent_units + 1;
    @(negedge clk);
  endtask

  // stop sending, let every expected byte arrive and the pipeline settle
  task automatic wait_idle();
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // one configuration transaction, only while the block is idle
  task automatic write_reg(input logic idx, input logic val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // unit drawn from the classes that matter to the encoder
  function automatic logic [15:0] rand_unit();
    int          kind;
    logic [15:0] u;
    kind = $urandom_range(0, 99);
    u    = 16'($urandom_range(0, 16'hFFFF));
    if (kind < 25) begin
      u = 16'($urandom_range(0, 16'h7F));
    end else if (kind < 40) begin
      u = 16'($urandom_range(16'h80, 16'h7FF));
    end else if (kind < 58) begin
      // three byte range, kept out of the surrogate block
      u = 16'($urandom_range(16'h800, 16'hFFFF));
      if (u >= 16'hD800 && u <= 16'hDFFF) u = u ^ 16'h2000;
    end else if (kind < 68) begin
      u = 16'hD800 | 16'($urandom_range(0, 1023));
    end else if (kind < 76) begin
      u = 16'hDC00 | 16'($urandom_range(0, 1023));
    end else if (kind < 84) begin
      case ($urandom_range(0, 7))
        0:       u = 16'h0000;
        1:       u = 16'h007F;
        2:       u = 16'h0080;
        3:       u = 16'h07FF;
        4:       u = 16'h0800;
        5:       u = 16'hD7FF;
        6:       u = 16'hE000;
        default: u = 16'hFFFF;
      endcase
    end
    return u;
  endfunction

  // a string of one to eight units, mostly well formed, ending with last_unit set
  task automatic send_random_string();
    int          len;
    int          i;
    logic [15:0] hi;
    logic [15:0] lo;
    len = $urandom_range(1, 8);
    i   = 0;
    while (i < len) begin
      if (i + 1 < len && $urandom_range(0, 99) < 20) begin
        // proper surrogate pair with random payload
        hi = 16'hD800 | 16'($urandom_range(0, 1023));
        lo = 16'hDC00 | 16'($urandom_range(0, 1023));
        send_unit(hi, 1'b0);
        send_unit(lo, i + 2 == len);
        i = i + 2;
      end else begin
        send_unit(rand_unit(), i + 1 == len);
        i = i + 1;
      end
    end
  endtask

  initial begin
    logic fmt;
    logic skip;
    int   k;
    int   target;

    sb           = new();
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_code_unit = '0;
    in_last_unit = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = t2u8_pkg::CFG_SOURCE_FORMAT;
    cfg_data     = 1'b0;
    in_idle_pct  = 7;
    out_idle_pct = 60;
    hold_cycles  = 0;
    sent_units   = 0;
    quiet_cycles = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: reset registers, utf-16 boundaries of each byte length
    send_unit(16'h0000, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFF, 1'b1);
    // lowest and highest surrogate pairs
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    // held high released by a plain unit, then by another high that pairs with a low, then a lone low
    send_unit(16'hD834, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hD801, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDC00, 1'b0);
    // string ends on a high surrogate, alone and after another held one
    send_unit(16'hDABC, 1'b1);
    send_unit(16'hD812, 1'b0);
    send_unit(16'hDBAA, 1'b1);

    // byte order mark dropped, including a one-unit string that vanishes
    wait_idle();
    write_reg(t2u8_pkg::CFG_SKIP_FIRST_UNIT, 1'b1);
    send_unit(16'hFEFF, 1'b0);
    send_unit(16'h0042, 1'b1);
    send_unit(16'hFFFE, 1'b1);
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0045, 1'b1);

    // latin-1 thresholds, high byte ignored, skip register ignored
    wait_idle();
    write_reg(t2u8_pkg::CFG_SOURCE_FORMAT, t2u8_pkg::FMT_LATIN1);
    send_unit(16'hFF00, 1'b0);
    send_unit(16'h007F, 1'b0);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h00BF, 1'b0);
    send_unit(16'h00C0, 1'b0);
    send_unit(16'hFFFF, 1'b1);

    // a surrogate held across a switch to latin-1 is discarded
    wait_idle();
    write_reg(t2u8_pkg::CFG_SOURCE_FORMAT, t2u8_pkg::FMT_UTF16);
    write_reg(t2u8_pkg::CFG_SKIP_FIRST_UNIT, 1'b0);
    send_unit(16'hD900, 1'b0);
    wait_idle();
    write_reg(t2u8_pkg::CFG_SOURCE_FORMAT, t2u8_pkg::FMT_LATIN1);
    send_unit(16'h12E5, 1'b0);
    wait_idle();
    write_reg(t2u8_pkg::CFG_SOURCE_FORMAT, t2u8_pkg::FMT_UTF16);
    send_unit(16'hDC00, 1'b1);

    // random part: three idling phases of three blocks, registers set per block
    for (int ph = 0; ph < 3; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          in_idle_pct  = 7;
          out_idle_pct = 60;
        end
        1: begin
          in_idle_pct  = 60;
          out_idle_pct = 7;
        end
        default: begin
          in_idle_pct  = 0;
          out_idle_pct = 0;
        end
      endcase
      for (int blk = 0; blk < 3; blk++) begin
        k = ph * 3 + blk;
        wait_idle();
        case (k)
          0: begin
            fmt  = t2u8_pkg::FMT_UTF16;
            skip = 1'b0;
          end
          1: begin
            fmt  = t2u8_pkg::FMT_LATIN1;
            skip = 1'b0;
          end
          2: begin
            fmt  = t2u8_pkg::FMT_UTF16;
            skip = 1'b1;
          end
          3: begin
            fmt  = t2u8_pkg::FMT_LATIN1;
            skip = 1'b1;
          end
          default: begin
            // utf-16 carries most of the interesting behavior
            fmt  = ($urandom_range(0, 99) < 70) ? t2u8_pkg::FMT_UTF16 : t2u8_pkg::FMT_LATIN1;
            skip = 1'($urandom_range(0, 1));
          end
        endcase
        write_reg(t2u8_pkg::CFG_SOURCE_FORMAT, fmt);
        write_reg(t2u8_pkg::CFG_SKIP_FIRST_UNIT, skip);
        // long receiver hold-off while the sender keeps pushing, fills the block
        if (ph == 2 && blk == 0) hold_cycles = HOLD_OFF_CYCLES;
        target = sent_units + BLOCK_UNITS;
        while (sent_units < target) send_random_string();
      end
    end

    wait_idle();
    if (sb.fail_count == 0)
      $display("text_to_utf8_transcoder_top regression: pass");
    else
      $display("text_to_utf8_transcoder_top regression: fail");
    $finish;
  end

endmodule
